[rtl/core/gif_lzw_pkg.sv]
`timescale 1ns / 1ps
package gif_lzw_pkg;
  localparam int HashSlots = 8192;
  localparam int DictCodes = 4096;
  localparam int MaxWidth = 12;
  localparam logic [3:0] MinBitsReset = 4'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR_MEM, ST_START, ST_RD, ST_CMP, ST_PUT, ST_ADD, ST_PUTCLR,
    ST_PUTSTR, ST_PUTEND, ST_FLUSH, ST_DRAIN
  } state_e;

  typedef struct packed {
    logic        put;
    logic [11:0] code;
    logic [3:0]  width;
  } put_req_t;
endpackage

[rtl/core/gif_lzw_ram.sv]
`timescale 1ns / 1ps
module gif_lzw_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[rtl/core/gif_lzw_packer.sv]
`timescale 1ns / 1ps
module gif_lzw_packer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   flush_i,
  input  logic                   drop_i,
  input  gif_lzw_pkg::put_req_t  req_i,
  input  logic                   pop_i,
  output logic [7:0]             byte_o,
  output logic                   have_byte_o,
  output logic                   have_bits_o,
  output logic [4:0]             cnt_o
);
  import gif_lzw_pkg::*;
  logic [23:0] bits_q, bits_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [11:0] mask;

  assign byte_o      = bits_q[7:0];
  assign have_byte_o = cnt_q >= 5'd8;
  assign have_bits_o = cnt_q != 5'd0;
  assign cnt_o       = cnt_q;
  assign mask        = 12'((13'd1 << req_i.width) - 13'd1);

  always_comb begin
    bits_d = bits_q;
    cnt_d  = cnt_q;
    if (drop_i) begin
      bits_d = '0;
      cnt_d  = '0;
    end else if (flush_i) begin
      bits_d = '0;
      cnt_d  = '0;
    end else if (pop_i) begin
      bits_d = bits_q >> 8;
      cnt_d  = cnt_q - 5'd8;
    end else if (req_i.put) begin
      bits_d = bits_q | (24'(req_i.code & mask) << cnt_q);
      cnt_d  = cnt_q + 5'(req_i.width);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      cnt_q  <= '0;
    end else begin
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
    end
  end

  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.put && !pop_i && !drop_i && !flush_i |-> cnt_q < 5'd8)
    else $error("put with a whole byte pending");
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i && !drop_i |-> cnt_q >= 5'd8) else $error("pop without byte");
  a_flush_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_i |-> cnt_q < 5'd8) else $error("flush with whole byte");
endmodule

[rtl/core/gif_lzw_code_stream_encoder.sv]
`timescale 1ns / 1ps
// GIF LZW code-stream encoder. Takes one palette index per item and gives the
// LZW code stream as bytes, LSB first, one byte per output item; run_end_o
// flags the last byte caused by an input item and stream_end_o the final byte
// of an image. A sequencer runs each dictionary probe as a read state and a
// compare state through a linear-probed hash table held in RAM (HASH_SLOTS
// must be a power of two), and one shared bit packer takes the codes and
// drains bytes one per cycle while the output is not stalled. The input is
// stalled while an item is worked on. A hit extends the current string; a
// miss puts its code and then adds an entry; the first symbol of a stream
// puts the clear code; a full dictionary puts the clear code and wipes the
// table instead of adding; the last symbol of a stream then adds the string
// code, the end code and the partial byte. A waiting byte that is stalled
// holds the item back. The used flags are wiped by a clearing pass over all
// HASH_SLOTS slots after reset, at the start of a stream when the previous
// one added entries, and when the dictionary fills up. A configuration write
// is taken only while idle and abandons the current stream, dropping its
// pending bits.
module gif_lzw_code_stream_encoder #(
  parameter int HASH_SLOTS = gif_lzw_pkg::HashSlots
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] symbol_i,
  input  logic       last_symbol_i,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       stream_end_o,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data_i
);
  import gif_lzw_pkg::*;
  localparam int AW = $clog2(HASH_SLOTS);

  state_e        state_q, state_d;
  state_e        ret_q, ret_d;
  logic [3:0]    mcb_q;
  logic [3:0]    eb;
  logic [8:0]    clear_code;
  logic [7:0]    sym_in;
  logic [7:0]    sym_q;
  logic          last_q;
  logic [11:0]   cur_q, cur_d;
  logic [12:0]   next_q, next_d;
  logic [3:0]    cw_q, cw_d;
  logic          started_q, started_d;
  logic          dirty_q, dirty_d;
  logic          fin_q, fin_d;
  logic          free_q, free_d;
  logic [AW-1:0] h_q, h_d;
  logic [AW-1:0] probes_q, probes_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          clr_done;
  logic [19:0]   key;
  logic          probe_hit, probe_miss;
  logic          used_we, used_wd, used_rd;
  logic [AW-1:0] used_wa;
  logic          slot_we;
  logic [31:0]   slot_rd;
  put_req_t      req;
  logic          pop, flush, drop;
  logic [7:0]    pbyte;
  logic          have_byte, have_bits;
  logic [4:0]    pcnt;

  // Clamp the minimum code size to the legal GIF range
  always_comb begin
    eb = mcb_q;
    if (mcb_q < 4'd2) eb = 4'd2;
    if (mcb_q > 4'd8) eb = 4'd8;
  end
  assign clear_code = 9'd1 << eb;
  // Mask oversized symbols to the palette width
  assign sym_in     = symbol_i & 8'(clear_code - 9'd1);
  assign key        = {cur_q, sym_q};
  assign clr_done   = clr_q == AW'(HASH_SLOTS - 1);
  assign probe_hit  = used_rd && (slot_rd[31:12] == key);
  // A free slot ends the search; so does a table with every slot checked
  assign probe_miss = !used_rd || (!probe_hit && probes_q == AW'(HASH_SLOTS - 1));

  // Used flags and key/code pairs live in separate RAMs sharing the read address.
  gif_lzw_ram #(.Width(1), .Depth(HASH_SLOTS)) u_used (
    .clk_i, .we_i(used_we), .waddr_i(used_wa), .wdata_i(used_wd),
    .raddr_i(h_q), .rdata_o(used_rd));
  gif_lzw_ram #(.Width(32), .Depth(HASH_SLOTS)) u_slot (
    .clk_i, .we_i(slot_we), .waddr_i(h_q), .wdata_i({key, next_q[11:0]}),
    .raddr_i(h_q), .rdata_o(slot_rd));

  gif_lzw_packer u_pack (
    .clk_i, .rst_ni, .flush_i(flush), .drop_i(drop), .req_i(req), .pop_i(pop),
    .byte_o(pbyte), .have_byte_o(have_byte), .have_bits_o(have_bits),
    .cnt_o(pcnt));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR_MEM: if (clr_done) state_d = ret_q;
      ST_IDLE: begin
        if (cfg_valid) state_d = ST_IDLE;
        else if (in_valid) begin
          if (started_q) state_d = ST_RD;
          else state_d = dirty_q ? ST_CLEAR_MEM : ST_START;
        end
      end
      ST_START:  state_d = ST_DRAIN;
      ST_RD:     state_d = ST_CMP;
      ST_CMP: begin
        priority if (probe_miss) state_d = ST_PUT;
        else if (probe_hit) state_d = last_q ? ST_PUTSTR : ST_IDLE;
        else state_d = ST_RD;
      end
      ST_PUT:    state_d = ST_DRAIN;
      ST_ADD:    state_d = last_q ? ST_PUTSTR : ST_IDLE;
      ST_PUTCLR: state_d = ST_DRAIN;
      ST_PUTSTR: state_d = ST_DRAIN;
      ST_PUTEND: state_d = ST_DRAIN;
      ST_FLUSH:  if (!have_bits || !out_stall) state_d = ST_IDLE;
      ST_DRAIN:  if (!have_byte) state_d = ret_q;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer datapath and handshake outputs
  always_comb begin
    cur_d = cur_q; next_d = next_q; cw_d = cw_q; started_d = started_q;
    dirty_d = dirty_q; fin_d = fin_q; free_d = free_q; ret_d = ret_q;
    h_d = h_q; probes_d = probes_q; clr_d = clr_q;
    used_we = 1'b0; used_wd = 1'b0; used_wa = h_q; slot_we = 1'b0;
    req = '0; pop = 1'b0; flush = 1'b0; drop = 1'b0;
    out_valid = 1'b0;
    unique case (state_q)
      ST_CLEAR_MEM: begin
        // wipe one used flag per cycle
        used_we = 1'b1; used_wa = clr_q; clr_d = clr_q + AW'(1);
        if (clr_done) dirty_d = 1'b0;
      end
      ST_IDLE: begin
        if (cfg_valid) begin
          // abandon the stream; the next symbol starts afresh
          drop = 1'b1; started_d = 1'b0; cur_d = '0;
        end else if (in_valid) begin
          h_d = AW'({cur_q, sym_in}); probes_d = '0;
          if (!started_q && dirty_q) begin
            clr_d = '0; ret_d = ST_START;
          end
        end
      end
      ST_START: begin
        req.put = 1'b1; req.code = 12'(clear_code); req.width = eb + 4'd1;
        cw_d = eb + 4'd1; next_d = 13'(clear_code) + 13'd2;
        cur_d = 12'(sym_q); started_d = 1'b1;
        fin_d = !last_q; ret_d = last_q ? ST_PUTSTR : ST_IDLE;
      end
      ST_RD: ;
      ST_CMP: begin
        priority if (probe_miss) free_d = !used_rd;
        else if (probe_hit) cur_d = slot_rd[11:0];
        else begin
          // advance to the next slot
          h_d = h_q + AW'(1); probes_d = probes_q + AW'(1);
        end
      end
      ST_PUT: begin
        req.put = 1'b1; req.code = cur_q; req.width = cw_q;
        if (next_q < 13'(DictCodes)) begin
          fin_d = !last_q; ret_d = ST_ADD;
        end else begin
          fin_d = 1'b0; ret_d = ST_PUTCLR;
        end
      end
      ST_ADD: begin
        if (free_q) begin
          used_we = 1'b1; used_wd = 1'b1; slot_we = 1'b1; dirty_d = 1'b1;
        end
        next_d = next_q + 13'd1;
        if (cw_q < 4'(MaxWidth) && (next_q + 13'd1) > (13'd1 << cw_q)) cw_d = cw_q + 4'd1;
        cur_d = 12'(sym_q);
      end
      ST_PUTCLR: begin
        // clear code at the old width, then reset the code numbering
        req.put = 1'b1; req.code = 12'(clear_code); req.width = cw_q;
        next_d = 13'(clear_code) + 13'd2; cw_d = eb + 4'd1;
        cur_d = 12'(sym_q); fin_d = !last_q; ret_d = ST_CLEAR_MEM;
      end
      ST_PUTSTR: begin
        req.put = 1'b1; req.code = cur_q; req.width = cw_q;
        fin_d = 1'b0; ret_d = ST_PUTEND;
      end
      ST_PUTEND: begin
        req.put = 1'b1; req.code = 12'(clear_code) + 12'd1; req.width = cw_q;
        fin_d = 1'b1; ret_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        out_valid = have_bits;
        if (!have_bits || !out_stall) begin
          flush = 1'b1; started_d = 1'b0;
        end
      end
      ST_DRAIN: begin
        if (have_byte) begin
          out_valid = 1'b1;
          if (!out_stall) pop = 1'b1;
        end else if (ret_q == ST_CLEAR_MEM) begin
          clr_d = '0; ret_d = last_q ? ST_PUTSTR : ST_IDLE;
        end
      end
      default: ;
    endcase
  end

  // The byte on the port ends the item when the final code of the item has
  // been put and no whole byte follows; for the last symbol a partial byte
  // left over goes out from the flush state instead.
  assign out_byte_o = pbyte;
  always_comb begin
    run_end_o = 1'b0; stream_end_o = 1'b0;
    if (state_q == ST_FLUSH) begin
      run_end_o = 1'b1; stream_end_o = 1'b1;
    end else if (state_q == ST_DRAIN && fin_q) begin
      if (last_q) begin
        run_end_o    = pcnt == 5'd8;
        stream_end_o = pcnt == 5'd8;
      end else begin
        run_end_o = pcnt < 5'd16;
      end
    end
  end

  assign in_stall  = state_q != ST_IDLE || cfg_valid;
  assign cfg_ready = state_q == ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR_MEM; ret_q <= ST_IDLE; mcb_q <= MinBitsReset;
      cur_q <= '0; next_q <= (13'd1 << MinBitsReset) + 13'd2;
      cw_q <= MinBitsReset + 4'd1; started_q <= 1'b0; dirty_q <= 1'b1;
      fin_q <= 1'b0; free_q <= 1'b0; h_q <= '0; probes_q <= '0; clr_q <= '0;
      sym_q <= '0; last_q <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; cur_q <= cur_d; next_q <= next_d;
      cw_q <= cw_d; started_q <= started_d; dirty_q <= dirty_d; fin_q <= fin_d;
      free_q <= free_d; h_q <= h_d; probes_q <= probes_d; clr_q <= clr_d;
      if (cfg_valid && cfg_ready) mcb_q <= cfg_data_i;
      if (state_q == ST_IDLE && in_valid && !in_stall) begin
        sym_q <= sym_in; last_q <= last_symbol_i;
      end
    end
  end

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> in_stall) else $error("ready while busy");
  a_out_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> state_q == ST_DRAIN || state_q == ST_FLUSH)
    else $error("output outside drain");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_byte_o) &&
    $stable(run_end_o) && $stable(stream_end_o))
    else $error("stalled byte changed");
  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> cw_q <= 4'(MaxWidth)) else $error("code width overflow");
endmodule

[verif/tb_gif_lzw_code_stream_encoder.sv]
`timescale 1ns / 1ps
module tb_gif_lzw_code_stream_encoder;
  import gif_lzw_pkg::*;

  typedef struct {
    logic [7:0] sym;
    logic       last;
  } symbol_item_t;

  typedef struct {
    logic [7:0] code_byte;
    logic       run_end;
    logic       stream_end;
  } code_byte_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] symbol_i;
  logic       last_symbol_i;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte_o;
  logic       run_end_o;
  logic       stream_end_o;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data_i;

  gif_lzw_code_stream_encoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .symbol_i     (symbol_i),
    .last_symbol_i(last_symbol_i),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .stream_end_o (stream_end_o),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data_i   (cfg_data_i)
  );

  // Pending symbols for the driver and code bytes still owed by the block
  symbol_item_t symbol_q[$];
  code_byte_t   code_byte_q[$];

  // Encoder mirror: minimum code size and LZW state
  logic [3:0]  min_bits;
  int          lzw_dict[int];
  int          cur_string;
  int          next_free_code;
  int          code_bits;
  longint      bit_acc;
  int          bit_count;
  bit          in_stream;

  int mismatch_cnt;
  int items_in;
  int bytes_out;
  int streams_done;
  int dict_resets;
  int burst_left;
  int gap_left;
  int hold_left;
  int stall_mode;
  bit long_hold_done;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic int clear_code_of();
    int b;
    b = min_bits;
    if (b < 2) b = 2;
    if (b > 8) b = 8;
    return 1 << b;
  endfunction

  function automatic void empty_dict();
    lzw_dict.delete();
    next_free_code = clear_code_of() + 2;
    code_bits = $clog2(clear_code_of()) + 1;
  endfunction

  function automatic void restart_stream();
    empty_dict();
    cur_string = 0;
    bit_acc = 0;
    bit_count = 0;
    in_stream = 1'b0;
  endfunction

  // Append one code at the current width; peel off every whole byte
  function automatic void pack_code(int code, ref code_byte_t bytes[$]);
    int w;
    code_byte_t cb;
    w = (code_bits > 12) ? 12 : code_bits;
    bit_acc |= longint'(code & ((1 << w) - 1)) << bit_count;
    bit_count += w;
    while (bit_count >= 8) begin
      cb.code_byte = bit_acc[7:0];
      cb.run_end = 1'b0;
      cb.stream_end = 1'b0;
      bytes.push_back(cb);
      bit_acc >>= 8;
      bit_count -= 8;
    end
  endfunction

  // Work out the code bytes one accepted symbol causes
  function automatic void encode_symbol(logic [7:0] sym_in, logic last);
    int clr;
    int sym;
    int key;
    code_byte_t bytes[$];
    code_byte_t cb;
    clr = clear_code_of();
    sym = sym_in & (clr - 1);
    if (!in_stream) begin
      empty_dict();
      pack_code(clr, bytes);
      cur_string = sym;
      in_stream = 1'b1;
    end else begin
      key = ((cur_string & 12'hfff) << 8) | sym;
      if (lzw_dict.exists(key)) begin
        cur_string = lzw_dict[key];
      end else begin
        pack_code(cur_string, bytes);
        if (next_free_code < DictCodes) begin
          lzw_dict[key] = next_free_code;
          next_free_code++;
          if (code_bits < MaxWidth && next_free_code > (1 << code_bits)) code_bits++;
        end else begin
          // dictionary full: send clear and start over
          pack_code(clr, bytes);
          empty_dict();
          dict_resets++;
        end
        cur_string = sym;
      end
    end
    if (last) begin
      pack_code(cur_string, bytes);
      pack_code(clr + 1, bytes);
      if (bit_count > 0) begin
        cb.code_byte = bit_acc[7:0];
        cb.run_end = 1'b0;
        cb.stream_end = 1'b0;
        bytes.push_back(cb);
      end
      bit_acc = 0;
      bit_count = 0;
      in_stream = 1'b0;
      streams_done++;
      if (bytes.size() > 0) bytes[$].stream_end = 1'b1;
    end
    if (bytes.size() > 0) bytes[$].run_end = 1'b1;
    foreach (bytes[i]) code_byte_q.push_back(bytes[i]);
  endfunction

  // Driver: bursts of items with random gaps; hold the payload while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      symbol_i <= '0;
      last_symbol_i <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_symbol(symbol_i, last_symbol_i);
        items_in++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (symbol_q.size() > 0) begin
          in_valid <= 1'b1;
          symbol_i <= symbol_q[0].sym;
          last_symbol_i <= symbol_q[0].last;
          void'(symbol_q.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: own stall pattern, one long hold-off, compare every accepted byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      stall_mode <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        bytes_out++;
        if (code_byte_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: unexpected byte %h run_end %b stream_end %b",
                     out_byte_o, run_end_o, stream_end_o);
        end else begin
          if (out_byte_o !== code_byte_q[0].code_byte ||
              run_end_o !== code_byte_q[0].run_end ||
              stream_end_o !== code_byte_q[0].stream_end) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("ERROR: byte %0d exp %h/%b/%b got %h/%b/%b", bytes_out,
                       code_byte_q[0].code_byte, code_byte_q[0].run_end,
                       code_byte_q[0].stream_end, out_byte_o, run_end_o,
                       stream_end_o);
          end
          void'(code_byte_q.pop_front());
        end
      end
      if (!long_hold_done && items_in >= 120) begin
        // long hold-off so the block backs up into its input
        long_hold_done <= 1'b1;
        hold_left <= 600;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  task automatic push_symbol(int sym, bit last);
    symbol_item_t it;
    it.sym = sym[7:0];
    it.last = last;
    symbol_q.push_back(it);
  endtask

  // Stream of random content; mostly in-range symbols, some drawn from the full byte range
  task automatic push_stream(int len, int range_max);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) push_symbol($urandom_range(0, 255), i == len - 1);
      else push_symbol($urandom_range(0, range_max), i == len - 1);
    end
  endtask

  // Wait until every item has gone in and every byte has come out
  task automatic wait_drained();
    while (symbol_q.size() != 0 || in_valid || code_byte_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_min_bits(logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    min_bits = value;
    restart_stream();
  endtask

  initial begin
    logic [3:0] settings[8];
    int clr;
    settings = '{4'd2, 4'd0, 4'd8, 4'd15, 4'd1, 4'd5, 4'd9, 4'd3};
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_data_i = '0;
    mismatch_cnt = 0;
    items_in = 0;
    bytes_out = 0;
    streams_done = 0;
    dict_resets = 0;
    min_bits = MinBitsReset;
    restart_stream();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset setting, single-symbol stream, extremes, repeats, oversize
    push_symbol(0, 1'b1);
    push_symbol(255, 1'b1);
    push_symbol(127, 1'b0);
    for (int i = 0; i < 6; i++) push_symbol(127, 1'b0);
    push_symbol(0, 1'b0);
    push_symbol(200, 1'b0);
    push_symbol(0, 1'b1);
    wait_drained();
    // abandon a stream part way by a register write
    push_symbol(3, 1'b0);
    push_symbol(1, 1'b0);
    wait_drained();
    write_min_bits(4'd2);
    push_symbol(255, 1'b0);
    for (int i = 0; i < 8; i++) push_symbol(i & 3, 1'b0);
    push_symbol(2, 1'b1);
    wait_drained();

    // Random streams across several settings, the extremes among them
    foreach (settings[s]) begin
      write_min_bits(settings[s]);
      clr = clear_code_of();
      for (int k = 0; k < 3; k++) push_stream($urandom_range(2, 20), clr - 1);
      wait_drained();
    end

    // A longer stream at the widest setting
    write_min_bits(4'd8);
    push_stream(25, 255);
    wait_drained();

    $display("Covered %0d symbols in %0d streams, %0d bytes checked, %0d dictionary resets",
             items_in, streams_done, bytes_out, dict_resets);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Timeout");
    $display("Regression FAIL");
    $finish;
  end
endmodule
